/* rtl/hbbs_pkg.sv */
// Package for the stereo head-bump bandpass block: widths, register and op codes,
// sequencer states, the state-memory request struct and saturation helpers.
// No dependencies.
package hbbs_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int DRIVE_W    = 30;
  localparam int WET_W      = 17;
  localparam int COEF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DRIVE_W-1:0] DRIVE_RESET = 30'd53687091;
  localparam logic [WET_W-1:0]   WET_RESET   = 17'd32768;
  localparam logic [WET_W-1:0]   WET_FULL    = 17'd65536;

  // Cubic coefficient, Q0.16
  localparam logic [15:0] CUBIC_COEF_Q16 = 16'd4050;

  // Integrator, cube intermediates and biquad words
  localparam int H_W   = 32;
  localparam int H2_W  = 39;
  localparam int T_W   = 38;
  localparam int Y_W   = 40;
  localparam int FF_W  = 42;
  localparam int ACC_W = 57;
  localparam int VAL_W = 60;
  localparam int MAG_W = 58;

  // Shared multiplier: A is taken in two halves against a full B
  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 32;
  localparam int MUL_SPLIT = 20;
  localparam int MUL_HI_W  = MUL_A_W - MUL_SPLIT;
  localparam int MUL_PP_W  = MUL_SPLIT + MUL_B_W;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  localparam int SH_DRIVE  = 29;
  localparam int SH_SQUARE = 24;
  localparam int SH_CUBEC  = 16;
  localparam int SH_CUBE   = 24;
  localparam int SH_COEF   = 30;
  localparam int SH_MIX    = 17;

  // State memory: one row of entries per channel
  localparam int ST_W     = 40;
  localparam int ENT_W    = 3;
  localparam int ST_AW    = 1 + ENT_W;
  localparam int ST_DEPTH = 2 ** ST_AW;

  localparam logic [ENT_W-1:0] ENT_H     = 3'd0;
  localparam logic [ENT_W-1:0] ENT_S1A   = 3'd1;
  localparam logic [ENT_W-1:0] ENT_S2A   = 3'd2;
  localparam logic [ENT_W-1:0] ENT_S1B   = 3'd3;
  localparam logic [ENT_W-1:0] ENT_S2B   = 3'd4;
  localparam logic [ENT_W-1:0] ENT_COUNT = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRIVE_GAIN,
    REG_WET_FRACTION,
    REG_FIRST_A0,
    REG_FIRST_B1,
    REG_FIRST_B2,
    REG_SECOND_A0,
    REG_SECOND_B1,
    REG_SECOND_B2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT,
    ST_POST,
    ST_FLUSH
  } seq_state_t;

  typedef enum logic [3:0] {
    OP_DRIVE,
    OP_SQUARE,
    OP_CUBE_COEF,
    OP_CUBE,
    OP_BQ1_FF,
    OP_BQ1_B1,
    OP_BQ1_B2,
    OP_BQ2_FF,
    OP_BQ2_B1,
    OP_BQ2_B2,
    OP_MIX_WET,
    OP_MIX_DRY
  } op_t;

  typedef struct packed {
    logic             re;
    logic [ST_AW-1:0] raddr;
    logic             we;
    logic [ST_AW-1:0] waddr;
  } mem_req_t;

  function automatic logic signed [23:0] sat24(input logic signed [VAL_W-1:0] v);
    logic signed [23:0] r;
    if (v[VAL_W-1:23] == {(VAL_W-23){v[VAL_W-1]}}) r = v[23:0];
    else if (v[VAL_W-1]) r = {1'b1, 23'b0};
    else r = {1'b0, {23{1'b1}}};
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [VAL_W-1:0] v);
    logic signed [31:0] r;
    if (v[VAL_W-1:31] == {(VAL_W-31){v[VAL_W-1]}}) r = v[31:0];
    else if (v[VAL_W-1]) r = {1'b1, 31'b0};
    else r = {1'b0, {31{1'b1}}};
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [VAL_W-1:0] v);
    logic signed [39:0] r;
    if (v[VAL_W-1:39] == {(VAL_W-39){v[VAL_W-1]}}) r = v[39:0];
    else if (v[VAL_W-1]) r = {1'b1, 39'b0};
    else r = {1'b0, {39{1'b1}}};
    return r;
  endfunction

endpackage

/* rtl/hbbs_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered data.
// Depends on hbbs_pkg for default sizes only.
module hbbs_ram #(
  parameter int WIDTH = hbbs_pkg::ST_W,
  parameter int DEPTH = hbbs_pkg::ST_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/hbbs_mul.sv */
// Shared unsigned multiplier: product of a 40-bit and a 32-bit magnitude, taken in halves.
// Depends on hbbs_pkg for operand and product widths.
module hbbs_mul (
  input  logic                         clk,
  input  logic                         start,
  input  logic [hbbs_pkg::MUL_A_W-1:0] a,
  input  logic [hbbs_pkg::MUL_B_W-1:0] b,
  output logic [hbbs_pkg::PROD_W-1:0]  prod
);

  logic [hbbs_pkg::MUL_HI_W-1:0] a_hi;
  logic [hbbs_pkg::MUL_B_W-1:0]  b_q;
  logic [hbbs_pkg::MUL_PP_W-1:0] p_lo;
  logic [hbbs_pkg::MUL_PP_W-1:0] p_hi;

  assign p_hi = a_hi * b_q;

  // On start the low half product is registered; the high half is then folded in at prod
  always_ff @(posedge clk) begin
    if (start) begin
      p_lo <= a[hbbs_pkg::MUL_SPLIT-1:0] * b;
      a_hi <= a[hbbs_pkg::MUL_A_W-1:hbbs_pkg::MUL_SPLIT];
      b_q  <= b;
    end
    prod <= {p_hi, {hbbs_pkg::MUL_SPLIT{1'b0}}} + hbbs_pkg::PROD_W'(p_lo);
  end

endmodule

/* rtl/hbbs_store.sv */
// State store: integrators and biquad delays in one RAM, with per-entry valid bits
// so that never-written entries read as zero after reset. Depends on hbbs_pkg, hbbs_ram.
module hbbs_store (
  input  logic                      clk,
  input  logic                      rst,
  input  hbbs_pkg::mem_req_t        req,
  input  logic [hbbs_pkg::ST_W-1:0] wdata,
  output logic [hbbs_pkg::ST_W-1:0] rdata
);

  logic [hbbs_pkg::ST_DEPTH-1:0] vld;
  logic                          rd_vld;
  logic [hbbs_pkg::ST_W-1:0]     ram_q;

  hbbs_ram #(
    .WIDTH(hbbs_pkg::ST_W),
    .DEPTH(hbbs_pkg::ST_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (req.we),
    .waddr(req.waddr),
    .wdata(wdata),
    .re   (req.re),
    .raddr(req.raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_vld <= vld[req.raddr];
      end
    end
  end

  assign rdata = rd_vld ? ram_q : '0;

endmodule

/* rtl/head_bump_bandpass_stereo_top.sv */
// Stereo head-bump saturator with two cascaded bandpass biquads and dry/wet mix.
// Each channel first loads its row of the state memory, then runs 12 products through
// the shared multiplier. A new input frame is taken only after the last one has
// reached the output register, which holds it while the output is stalled.
// Reset: registers take their reset values; valid bits make the state memory read zero.
module head_bump_bandpass_stereo_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [hbbs_pkg::SAMPLE_W-1:0]  sample_left,
  input  logic signed [hbbs_pkg::SAMPLE_W-1:0]  sample_right,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [hbbs_pkg::SAMPLE_W-1:0]  out_left,
  output logic signed [hbbs_pkg::SAMPLE_W-1:0]  out_right,
  input  logic                                  cfg_write,
  input  logic [hbbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hbbs_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int VW = hbbs_pkg::VAL_W;

  // Configuration registers
  logic [hbbs_pkg::DRIVE_W-1:0]       drive_gain;
  logic [hbbs_pkg::WET_W-1:0]         wet_fraction;
  logic signed [hbbs_pkg::COEF_W-1:0] first_a0, first_b1, first_b2;
  logic signed [hbbs_pkg::COEF_W-1:0] second_a0, second_b1, second_b2;

  // Sequencer
  hbbs_pkg::seq_state_t           state, state_next;
  hbbs_pkg::op_t                  op;
  logic                           ch;
  logic [hbbs_pkg::ENT_W-1:0]     ld_cnt;
  logic                           out_free;

  // Working registers
  logic signed [hbbs_pkg::SAMPLE_W-1:0] x_l, x_r;
  logic signed [hbbs_pkg::H_W-1:0]      h;
  logic [hbbs_pkg::H2_W-1:0]            h2;
  logic [hbbs_pkg::T_W-1:0]             t;
  logic signed [hbbs_pkg::Y_W-1:0]      s1a, s2a, s1b, s2b;
  logic signed [hbbs_pkg::FF_W-1:0]     ff;
  logic signed [hbbs_pkg::Y_W-1:0]      y;
  logic signed [hbbs_pkg::ACC_W-1:0]    acc;
  logic signed [hbbs_pkg::SAMPLE_W-1:0] o_l, o_r;
  logic                                 neg_q;

  // Memory and multiplier
  hbbs_pkg::mem_req_t              mem_req;
  logic [hbbs_pkg::ST_W-1:0]       mem_wdata;
  logic [hbbs_pkg::ST_W-1:0]       mem_rdata;
  logic [hbbs_pkg::ENT_W-1:0]      wr_ent;
  logic                            mul_start;
  logic [hbbs_pkg::MUL_A_W-1:0]    mul_a;
  logic [hbbs_pkg::MUL_B_W-1:0]    mul_b;
  logic                            mul_neg;
  logic [hbbs_pkg::PROD_W-1:0]     prod;

  // Operand helpers
  logic signed [hbbs_pkg::SAMPLE_W-1:0] x_cur;
  logic [hbbs_pkg::SAMPLE_W-1:0]        x_mag;
  logic [hbbs_pkg::H_W-1:0]             h_mag;
  logic [hbbs_pkg::Y_W-1:0]             y_mag;
  logic signed [hbbs_pkg::COEF_W-1:0]   coef;
  logic [hbbs_pkg::COEF_W-1:0]          coef_mag;
  logic [hbbs_pkg::WET_W-1:0]           wet_eff;
  logic [hbbs_pkg::WET_W-1:0]           dry_w;
  logic                                 bq2;

  // Post-multiply values
  logic [hbbs_pkg::MAG_W-1:0]           mag_q;
  logic signed [VW-1:0]                 sv;
  logic signed [VW-1:0]                 h_x, s1_x, s2_x, ff_x, acc_x;
  logic signed [hbbs_pkg::H_W-1:0]      h_drive, h_cube;
  logic signed [hbbs_pkg::Y_W-1:0]      y_new, s1_new, s2_new;
  logic signed [VW-1:0]                 mix_sum;
  logic [VW-1:0]                        mix_mag, mix_shr;
  logic signed [VW-1:0]                 mix_o;
  logic signed [hbbs_pkg::SAMPLE_W-1:0] o_sat;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain   <= hbbs_pkg::DRIVE_RESET;
      wet_fraction <= hbbs_pkg::WET_RESET;
      first_a0     <= '0;
      first_b1     <= '0;
      first_b2     <= '0;
      second_a0    <= '0;
      second_b1    <= '0;
      second_b2    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        hbbs_pkg::REG_DRIVE_GAIN:   drive_gain   <= cfg_data[hbbs_pkg::DRIVE_W-1:0];
        hbbs_pkg::REG_WET_FRACTION: wet_fraction <= cfg_data[hbbs_pkg::WET_W-1:0];
        hbbs_pkg::REG_FIRST_A0:     first_a0     <= cfg_data;
        hbbs_pkg::REG_FIRST_B1:     first_b1     <= cfg_data;
        hbbs_pkg::REG_FIRST_B2:     first_b2     <= cfg_data;
        hbbs_pkg::REG_SECOND_A0:    second_a0    <= cfg_data;
        hbbs_pkg::REG_SECOND_B1:    second_b1    <= cfg_data;
        hbbs_pkg::REG_SECOND_B2:    second_b2    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wet_eff = (wet_fraction > hbbs_pkg::WET_FULL) ? hbbs_pkg::WET_FULL : wet_fraction;
  assign dry_w   = hbbs_pkg::WET_FULL - wet_eff;

  // ---------------------------------------------------------------- units
  hbbs_store u_store (
    .clk  (clk),
    .rst  (rst),
    .req  (mem_req),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  hbbs_mul u_mul (
    .clk  (clk),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // ---------------------------------------------------------------- operands
  assign x_cur = ch ? x_r : x_l;
  assign x_mag = x_cur[hbbs_pkg::SAMPLE_W-1] ? hbbs_pkg::SAMPLE_W'(-x_cur)
                                             : hbbs_pkg::SAMPLE_W'(x_cur);
  assign h_mag = h[hbbs_pkg::H_W-1] ? hbbs_pkg::H_W'(-h) : hbbs_pkg::H_W'(h);
  assign y_mag = y[hbbs_pkg::Y_W-1] ? hbbs_pkg::Y_W'(-y) : hbbs_pkg::Y_W'(y);
  assign coef_mag = coef[hbbs_pkg::COEF_W-1] ? hbbs_pkg::COEF_W'(-coef)
                                             : hbbs_pkg::COEF_W'(coef);

  assign bq2 = (op == hbbs_pkg::OP_BQ2_FF) || (op == hbbs_pkg::OP_BQ2_B1) ||
               (op == hbbs_pkg::OP_BQ2_B2);

  always_comb begin
    case (op)
      hbbs_pkg::OP_BQ1_FF: coef = first_a0;
      hbbs_pkg::OP_BQ1_B1: coef = first_b1;
      hbbs_pkg::OP_BQ1_B2: coef = first_b2;
      hbbs_pkg::OP_BQ2_FF: coef = second_a0;
      hbbs_pkg::OP_BQ2_B1: coef = second_b1;
      hbbs_pkg::OP_BQ2_B2: coef = second_b2;
      default:             coef = '0;
    endcase
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (op)
      hbbs_pkg::OP_DRIVE: begin
        mul_a   = hbbs_pkg::MUL_A_W'(drive_gain);
        mul_b   = hbbs_pkg::MUL_B_W'(x_mag);
        mul_neg = x_cur[hbbs_pkg::SAMPLE_W-1];
      end
      hbbs_pkg::OP_SQUARE: begin
        mul_a = hbbs_pkg::MUL_A_W'(h_mag);
        mul_b = hbbs_pkg::MUL_B_W'(h_mag);
      end
      hbbs_pkg::OP_CUBE_COEF: begin
        mul_a = hbbs_pkg::MUL_A_W'(h2);
        mul_b = hbbs_pkg::MUL_B_W'(hbbs_pkg::CUBIC_COEF_Q16);
      end
      hbbs_pkg::OP_CUBE: begin
        mul_a = hbbs_pkg::MUL_A_W'(t);
        mul_b = hbbs_pkg::MUL_B_W'(h_mag);
      end
      hbbs_pkg::OP_BQ1_FF: begin
        mul_a   = hbbs_pkg::MUL_A_W'(h_mag);
        mul_b   = coef_mag;
        mul_neg = h[hbbs_pkg::H_W-1] ^ coef[hbbs_pkg::COEF_W-1];
      end
      hbbs_pkg::OP_BQ1_B1, hbbs_pkg::OP_BQ1_B2, hbbs_pkg::OP_BQ2_FF,
      hbbs_pkg::OP_BQ2_B1, hbbs_pkg::OP_BQ2_B2: begin
        mul_a   = hbbs_pkg::MUL_A_W'(y_mag);
        mul_b   = coef_mag;
        mul_neg = y[hbbs_pkg::Y_W-1] ^ coef[hbbs_pkg::COEF_W-1];
      end
      hbbs_pkg::OP_MIX_WET: begin
        mul_a   = hbbs_pkg::MUL_A_W'(y_mag);
        mul_b   = hbbs_pkg::MUL_B_W'(wet_eff);
        mul_neg = y[hbbs_pkg::Y_W-1];
      end
      hbbs_pkg::OP_MIX_DRY: begin
        // dry sample enters as Q.24
        mul_a   = hbbs_pkg::MUL_A_W'({x_mag, 1'b0});
        mul_b   = hbbs_pkg::MUL_B_W'(dry_w);
        mul_neg = x_cur[hbbs_pkg::SAMPLE_W-1];
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- post
  always_comb begin
    case (op)
      hbbs_pkg::OP_DRIVE:     mag_q = hbbs_pkg::MAG_W'(prod >> hbbs_pkg::SH_DRIVE);
      hbbs_pkg::OP_SQUARE:    mag_q = hbbs_pkg::MAG_W'(prod >> hbbs_pkg::SH_SQUARE);
      hbbs_pkg::OP_CUBE_COEF: mag_q = hbbs_pkg::MAG_W'(prod >> hbbs_pkg::SH_CUBEC);
      hbbs_pkg::OP_CUBE:      mag_q = hbbs_pkg::MAG_W'(prod >> hbbs_pkg::SH_CUBE);
      hbbs_pkg::OP_MIX_WET,
      hbbs_pkg::OP_MIX_DRY:   mag_q = hbbs_pkg::MAG_W'(prod);
      default:                mag_q = hbbs_pkg::MAG_W'(prod >> hbbs_pkg::SH_COEF);
    endcase
  end

  // Truncate the magnitude, then apply the sign
  assign sv = neg_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});

  assign h_x   = $signed({{(VW-hbbs_pkg::H_W){h[hbbs_pkg::H_W-1]}}, h});
  assign s1_x  = bq2 ? $signed({{(VW-hbbs_pkg::Y_W){s1b[hbbs_pkg::Y_W-1]}}, s1b})
                     : $signed({{(VW-hbbs_pkg::Y_W){s1a[hbbs_pkg::Y_W-1]}}, s1a});
  assign s2_x  = bq2 ? $signed({{(VW-hbbs_pkg::Y_W){s2b[hbbs_pkg::Y_W-1]}}, s2b})
                     : $signed({{(VW-hbbs_pkg::Y_W){s2a[hbbs_pkg::Y_W-1]}}, s2a});
  assign ff_x  = $signed({{(VW-hbbs_pkg::FF_W){ff[hbbs_pkg::FF_W-1]}}, ff});
  assign acc_x = $signed({{(VW-hbbs_pkg::ACC_W){acc[hbbs_pkg::ACC_W-1]}}, acc});

  assign h_drive = hbbs_pkg::sat32(h_x + sv);
  // cube pulls the integrator toward zero
  assign h_cube  = hbbs_pkg::sat32(h[hbbs_pkg::H_W-1] ? h_x + sv : h_x - sv);
  assign y_new   = hbbs_pkg::sat40(sv + s1_x);
  assign s1_new  = hbbs_pkg::sat40(s2_x - sv);
  assign s2_new  = hbbs_pkg::sat40(-ff_x - sv);

  assign mix_sum = acc_x + sv;
  assign mix_mag = mix_sum[VW-1] ? VW'(-mix_sum) : VW'(mix_sum);
  assign mix_shr = mix_mag >> hbbs_pkg::SH_MIX;
  assign mix_o   = mix_sum[VW-1] ? -$signed(mix_shr) : $signed(mix_shr);
  assign o_sat   = hbbs_pkg::sat24(mix_o);

  // ---------------------------------------------------------------- control
  assign sample_stall = rst || (state != hbbs_pkg::ST_IDLE);
  assign out_free     = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hbbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    mul_start       = 1'b0;
    mem_req.re      = 1'b0;
    mem_req.raddr   = {ch, ld_cnt};
    mem_req.we      = 1'b0;
    wr_ent          = hbbs_pkg::ENT_H;
    mem_wdata       = '0;
    case (state)
      hbbs_pkg::ST_IDLE: begin
        if (sample_valid) begin
          state_next = hbbs_pkg::ST_LOAD;
        end
      end
      hbbs_pkg::ST_LOAD: begin
        mem_req.re = (ld_cnt < hbbs_pkg::ENT_COUNT);
        if (ld_cnt == hbbs_pkg::ENT_COUNT) begin
          state_next = hbbs_pkg::ST_ISSUE;
        end
      end
      hbbs_pkg::ST_ISSUE: begin
        mul_start  = 1'b1;
        state_next = hbbs_pkg::ST_WAIT;
      end
      hbbs_pkg::ST_WAIT: begin
        state_next = hbbs_pkg::ST_POST;
      end
      hbbs_pkg::ST_POST: begin
        case (op)
          hbbs_pkg::OP_CUBE: begin
            mem_req.we = 1'b1;
            wr_ent     = hbbs_pkg::ENT_H;
            mem_wdata  = {{(hbbs_pkg::ST_W-hbbs_pkg::H_W){h_cube[hbbs_pkg::H_W-1]}}, h_cube};
          end
          hbbs_pkg::OP_BQ1_B1: begin
            mem_req.we = 1'b1;
            wr_ent     = hbbs_pkg::ENT_S1A;
            mem_wdata  = s1_new;
          end
          hbbs_pkg::OP_BQ1_B2: begin
            mem_req.we = 1'b1;
            wr_ent     = hbbs_pkg::ENT_S2A;
            mem_wdata  = s2_new;
          end
          hbbs_pkg::OP_BQ2_B1: begin
            mem_req.we = 1'b1;
            wr_ent     = hbbs_pkg::ENT_S1B;
            mem_wdata  = s1_new;
          end
          hbbs_pkg::OP_BQ2_B2: begin
            mem_req.we = 1'b1;
            wr_ent     = hbbs_pkg::ENT_S2B;
            mem_wdata  = s2_new;
          end
          default: ;
        endcase
        if (op == hbbs_pkg::OP_MIX_DRY) begin
          state_next = ch ? hbbs_pkg::ST_FLUSH : hbbs_pkg::ST_LOAD;
        end else begin
          state_next = hbbs_pkg::ST_ISSUE;
        end
      end
      hbbs_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_next = hbbs_pkg::ST_IDLE;
        end
      end
      default: state_next = hbbs_pkg::ST_IDLE;
    endcase
    mem_req.waddr = {ch, wr_ent};
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst) begin
      ch     <= 1'b0;
      ld_cnt <= '0;
      op     <= hbbs_pkg::OP_DRIVE;
    end else begin
      case (state)
        hbbs_pkg::ST_IDLE: begin
          ch     <= 1'b0;
          ld_cnt <= '0;
        end
        hbbs_pkg::ST_LOAD: begin
          ld_cnt <= ld_cnt + 1'b1;
          op     <= hbbs_pkg::OP_DRIVE;
        end
        hbbs_pkg::ST_POST: begin
          if (op == hbbs_pkg::OP_MIX_DRY) begin
            // advance to the right channel
            ch     <= 1'b1;
            ld_cnt <= '0;
          end else begin
            op <= hbbs_pkg::op_t'(op + 4'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == hbbs_pkg::ST_IDLE && sample_valid) begin
      x_l <= sample_left;
      x_r <= sample_right;
    end
    if (state == hbbs_pkg::ST_ISSUE) begin
      neg_q <= mul_neg;
    end
    // read data arrives in the cycle after its address
    if (state == hbbs_pkg::ST_LOAD && ld_cnt != '0) begin
      case (hbbs_pkg::ENT_W'(ld_cnt - 1'b1))
        hbbs_pkg::ENT_H:   h   <= mem_rdata[hbbs_pkg::H_W-1:0];
        hbbs_pkg::ENT_S1A: s1a <= mem_rdata;
        hbbs_pkg::ENT_S2A: s2a <= mem_rdata;
        hbbs_pkg::ENT_S1B: s1b <= mem_rdata;
        hbbs_pkg::ENT_S2B: s2b <= mem_rdata;
        default: ;
      endcase
    end
    if (state == hbbs_pkg::ST_POST) begin
      case (op)
        hbbs_pkg::OP_DRIVE:     h  <= h_drive;
        hbbs_pkg::OP_SQUARE:    h2 <= mag_q[hbbs_pkg::H2_W-1:0];
        hbbs_pkg::OP_CUBE_COEF: t  <= mag_q[hbbs_pkg::T_W-1:0];
        hbbs_pkg::OP_CUBE:      h  <= h_cube;
        hbbs_pkg::OP_BQ1_FF, hbbs_pkg::OP_BQ2_FF: begin
          ff <= sv[hbbs_pkg::FF_W-1:0];
          y  <= y_new;
        end
        hbbs_pkg::OP_MIX_WET:   acc <= sv[hbbs_pkg::ACC_W-1:0];
        hbbs_pkg::OP_MIX_DRY: begin
          if (ch) begin
            o_r <= o_sat;
          end else begin
            o_l <= o_sat;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: hold the transaction until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == hbbs_pkg::ST_FLUSH && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hbbs_pkg::ST_FLUSH && out_free) begin
      out_left  <= o_l;
      out_right <= o_r;
    end
  end

endmodule

/* tb/head_bump_bandpass_stereo_top_tb.sv */
// Self-checking testbench for head_bump_bandpass_stereo_top: directed and random stereo
// frames, checked against a fixed-point model of the bump integrator, biquads and mix.
// Depends on hbbs_pkg and the RTL top only.
module head_bump_bandpass_stereo_top_tb;
  import hbbs_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 120;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [SAMPLE_W-1:0] sample_left = '0;
  logic signed [SAMPLE_W-1:0] sample_right = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register mirror and filter state of the model
  logic [DRIVE_W-1:0] drive_reg = DRIVE_RESET;
  logic [WET_W-1:0] wet_reg = WET_RESET;
  logic signed [COEF_W-1:0] bp_a0 [2] = '{0, 0};
  logic signed [COEF_W-1:0] bp_b1 [2] = '{0, 0};
  logic signed [COEF_W-1:0] bp_b2 [2] = '{0, 0};
  longint bump_h [2] = '{0, 0};
  longint bp_s1 [2][2] = '{'{0, 0}, '{0, 0}};
  longint bp_s2 [2][2] = '{'{0, 0}, '{0, 0}};

  frame_t mixed_frames_due [$];
  frame_t due_frame;
  int fail_count = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int settings_used = 0;
  int burst_left = 0;
  int stall_run = 0;
  int cyc = 0;

  head_bump_bandpass_stereo_top uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_left     (out_left),
    .out_right    (out_right),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clip(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Exact product of magnitudes, shifted down, sign restored (truncate toward zero)
  function automatic longint scaled_product(longint a, longint b, int sh);
    logic [63:0] ma, mb;
    logic [127:0] p;
    longint m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = ({64'd0, ma} * {64'd0, mb}) >> sh;
    m = longint'(p[63:0]);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint bandpass_stage(int stage, int ch, longint u);
    longint ff, y, ns1, ns2;
    ff = scaled_product(longint'(bp_a0[stage]), u, SH_COEF);
    y = clip(ff + bp_s1[stage][ch], Y_W);
    ns1 = clip(bp_s2[stage][ch] - scaled_product(longint'(bp_b1[stage]), y, SH_COEF), Y_W);
    ns2 = clip(-ff - scaled_product(longint'(bp_b2[stage]), y, SH_COEF), Y_W);
    bp_s1[stage][ch] = ns1;
    bp_s2[stage][ch] = ns2;
    return y;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] shape_channel(int ch, longint x);
    longint h, y2, w, acc, o;
    logic [63:0] m, h2, t, c3, am;
    logic [127:0] wide;
    h = clip(bump_h[ch] + scaled_product(longint'(drive_reg), x, SH_DRIVE), H_W);
    m = (h < 0) ? -h : h;
    h2 = (m * m) >> SH_SQUARE;
    t = (h2 * 64'(CUBIC_COEF_Q16)) >> SH_CUBEC;
    wide = {64'd0, m} * {64'd0, t};
    c3 = 64'(wide >> SH_CUBE);
    h = clip((h < 0) ? h + longint'(c3) : h - longint'(c3), H_W);
    bump_h[ch] = h;
    y2 = bandpass_stage(1, ch, bandpass_stage(0, ch, h));
    w = (wet_reg > WET_FULL) ? longint'(WET_FULL) : longint'(wet_reg);
    acc = y2 * w + (x * 2) * (longint'(WET_FULL) - w);
    am = (acc < 0) ? -acc : acc;
    o = longint'(am >> SH_MIX);
    if (acc < 0) o = -o;
    return SAMPLE_W'(clip(o, SAMPLE_W));
  endfunction

  function automatic frame_t bump_filter_frame(logic signed [SAMPLE_W-1:0] l,
                                               logic signed [SAMPLE_W-1:0] r);
    frame_t f;
    f.left = shape_channel(0, longint'(l));
    f.right = shape_channel(1, longint'(r));
    return f;
  endfunction

  // Receiver: quiet, light and heavy stall stretches in turn
  always @(negedge clk) begin
    cyc++;
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      case ((cyc / 2500) % 3)
        0: begin
          result_stall <= 1'b0;
          stall_run = 40;
        end
        1: begin
          if (result_stall) begin
            result_stall <= 1'b0;
            stall_run = $urandom_range(4, 40);
          end else begin
            result_stall <= 1'b1;
            stall_run = $urandom_range(0, 3);
          end
        end
        default: begin
          if (result_stall) begin
            result_stall <= 1'b0;
            stall_run = $urandom_range(0, 8);
          end else begin
            result_stall <= 1'b1;
            stall_run = $urandom_range(4, 60);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (mixed_frames_due.size() == 0) begin
        $display("%0t: result with none due: out_left %0d out_right %0d",
                 $time, out_left, out_right);
        fail_count++;
      end else begin
        due_frame = mixed_frames_due.pop_front();
        results_checked++;
        if (out_left !== due_frame.left) begin
          $display("%0t: out_left mismatch: expected %0d, got %0d",
                   $time, due_frame.left, out_left);
          fail_count++;
        end
        if (out_right !== due_frame.right) begin
          $display("%0t: out_right mismatch: expected %0d, got %0d",
                   $time, due_frame.right, out_right);
          fail_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_write || (sample_valid && !sample_stall) ||
          (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        sample_valid <= 1'b0;
        sample_left <= SAMPLE_W'($urandom);
        sample_right <= SAMPLE_W'($urandom);
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    sample_valid <= 1'b1;
    sample_left <= l;
    sample_right <= r;
    do @(posedge clk); while (sample_stall);
    mixed_frames_due.push_back(bump_filter_frame(l, r));
    frames_sent++;
  endtask

  // Drop valid and hold until every due result has been taken
  task automatic wait_for_idle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (mixed_frames_due.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_DRIVE_GAIN:   drive_reg = data[DRIVE_W-1:0];
      REG_WET_FRACTION: wet_reg = data[WET_W-1:0];
      REG_FIRST_A0:     bp_a0[0] = data;
      REG_FIRST_B1:     bp_b1[0] = data;
      REG_FIRST_B2:     bp_b2[0] = data;
      REG_SECOND_A0:    bp_a0[1] = data;
      REG_SECOND_B1:    bp_b1[1] = data;
      REG_SECOND_B2:    bp_b2[1] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stable bandpass: |b2| < 1 and |b1| < 1 + b2, a0 set from b2
  task automatic stable_bandpass(output logic [31:0] a0, output logic [31:0] b1,
                                 output logic [31:0] b2);
    longint one, p2, span, p1;
    one = longint'(1) << 30;
    p2 = $urandom_range(322122547, 1068373114);
    span = ((one + p2) * 98) / 100;
    p1 = longint'($urandom_range(0, 32'(2 * span))) - span;
    a0 = 32'((one - p2) / 2);
    if ($urandom_range(0, 1)) a0 = -a0;
    b1 = 32'(p1);
    b2 = 32'(p2);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int style;
    style = $urandom_range(0, 9);
    if (style < 6) return SAMPLE_W'($urandom);
    if (style < 9) return $signed(24'($urandom_range(0, 131070))) - 24'sd65535;
    case ($urandom_range(0, 2))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return '0;
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_frame('0, '0);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(-24'sd1, 24'sd1);
    send_frame(24'h555555, 24'hAAAAAA);
    settings_used++;
  endtask

  task automatic test_wet_mix_extremes();
    wait_for_idle();
    write_reg(REG_FIRST_A0, 32'sd268435456);
    write_reg(REG_FIRST_B1, -32'sd1610612736);
    write_reg(REG_FIRST_B2, 32'sd536870912);
    write_reg(REG_SECOND_A0, -32'sd268435456);
    write_reg(REG_SECOND_B1, -32'sd1610612736);
    write_reg(REG_SECOND_B2, 32'sd536870912);
    // dry only; upper bits beyond the register width are ignored
    write_reg(REG_WET_FRACTION, {15'h7FFF, 17'd0});
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame(24'sd1000, -24'sd1000);
    wait_for_idle();
    write_reg(REG_WET_FRACTION, 32'(WET_FULL));
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame('0, '0);
    wait_for_idle();
    // above full acts as full
    write_reg(REG_WET_FRACTION, 32'h0001FFFF);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(24'sd4096, -24'sd4096);
    settings_used += 3;
  endtask

  task automatic test_drive_extremes();
    wait_for_idle();
    write_reg(REG_DRIVE_GAIN, 32'hFFFFFFFF);
    repeat (3) send_frame(SAMPLE_MAX, SAMPLE_MIN);
    repeat (3) send_frame(SAMPLE_MIN, SAMPLE_MAX);
    wait_for_idle();
    write_reg(REG_DRIVE_GAIN, 32'd0);
    send_frame(SAMPLE_MAX, SAMPLE_MAX);
    settings_used += 2;
  endtask

  task automatic test_filter_runaway();
    wait_for_idle();
    write_reg(REG_DRIVE_GAIN, 32'(DRIVE_RESET));
    write_reg(REG_WET_FRACTION, 32'(WET_FULL));
    write_reg(REG_FIRST_A0, 32'h7FFFFFFF);
    write_reg(REG_FIRST_B1, 32'h80000000);
    write_reg(REG_FIRST_B2, 32'h80000000);
    write_reg(REG_SECOND_A0, 32'h7FFFFFFF);
    write_reg(REG_SECOND_B1, 32'h80000000);
    write_reg(REG_SECOND_B2, 32'h80000000);
    repeat (4) send_frame(SAMPLE_MAX, SAMPLE_MIN);
    settings_used++;
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    logic [31:0] a0, b1, b2;
    logic [DRIVE_W-1:0] drive;
    logic [WET_W-1:0] wet;
    bit wild;
    for (int p = 0; p < phases; p++) begin
      wait_for_idle();
      wild = (p % 3 == 2);
      case ($urandom_range(0, 4))
        0: drive = '0;
        1: drive = '1;
        2: drive = DRIVE_W'($urandom);
        default: drive = DRIVE_W'($urandom_range(1 << 20, 1 << 27));
      endcase
      case ($urandom_range(0, 4))
        0: wet = '0;
        1: wet = WET_FULL;
        2: wet = WET_W'($urandom_range(32'(WET_FULL) + 1, 131071));
        default: wet = WET_W'($urandom_range(0, 32'(WET_FULL)));
      endcase
      write_reg(REG_DRIVE_GAIN, {2'($urandom), drive});
      write_reg(REG_WET_FRACTION, {15'($urandom), wet});
      if (wild) {a0, b1, b2} = {32'($urandom), 32'($urandom), 32'($urandom)};
      else stable_bandpass(a0, b1, b2);
      write_reg(REG_FIRST_A0, a0);
      write_reg(REG_FIRST_B1, b1);
      write_reg(REG_FIRST_B2, b2);
      if (wild) {a0, b1, b2} = {32'($urandom), 32'($urandom), 32'($urandom)};
      else stable_bandpass(a0, b1, b2);
      write_reg(REG_SECOND_A0, a0);
      write_reg(REG_SECOND_B1, b1);
      write_reg(REG_SECOND_B2, b2);
      settings_used++;
      repeat (per_phase) send_frame(pick_sample(), pick_sample());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_wet_mix_extremes();
    test_drive_extremes();
    test_filter_runaway();
    test_random_settings(7, 155);
    wait_for_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mixed_frames_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, mixed_frames_due.size());
      fail_count++;
    end
    $display("Ran %0d stereo frames through %0d register settings (dry, wet, over-full mix,",
             frames_sent, settings_used);
    $display("drive and filter extremes); %0d results compared, %0d mismatches.",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
